>>> rtl/sbi_pkg.sv
// Shared widths, constants and stage types for the segment/box hit test.
package sbi_pkg;

  localparam int CW  = 24;           // coordinate width
  localparam int SW  = CW - 1;       // size width
  localparam int TF  = 16;           // fraction bits of the slab parameter
  localparam int QB  = TF + 2;       // quotient bits kept, covers up to 4.0
  localparam int AW  = CW + 1;       // doubled point
  localparam int BW  = CW + 2;       // doubled bound
  localparam int NW  = CW + 3;       // bound minus point
  localparam int DW  = CW + 2;       // doubled delta magnitude
  localparam int RW  = NW + TF;      // divider remainder
  localparam int TW  = QB + 1;       // signed slab parameter
  localparam int THW = 8;            // threshold register width
  localparam int DBW = 288;          // input tdata width
  localparam int OBW = 8;            // output tdata width

  typedef struct packed {
    logic          in_a;
    logic          in_b;
    logic          par;
    logic          pout;
    logic          lo_neg;
    logic          hi_neg;
    logic          d_neg;
    logic          lo_ovf;
    logic          hi_ovf;
    logic [NW-1:0] lo_mag;
    logic [NW-1:0] hi_mag;
    logic [DW-1:0] d_mag;
  } axis_setup_t;

  typedef struct packed {
    logic       enclosed;
    logic [2:0] par;
    logic [2:0] pout;
    logic [2:0] neg_lo;
    logic [2:0] neg_hi;
    logic [2:0] ovf_lo;
    logic [2:0] ovf_hi;
  } side_t;

endpackage

>>> rtl/sbi_axis.sv
// Per-axis setup: doubled bounds, inside and parallel tests, divider operands.
module sbi_axis (
  input  logic signed [sbi_pkg::CW-1:0]  a,
  input  logic signed [sbi_pkg::CW-1:0]  b,
  input  logic signed [sbi_pkg::CW-1:0]  c,
  input  logic        [sbi_pkg::SW-1:0]  s,
  input  logic        [sbi_pkg::THW-1:0] thr,
  output sbi_pkg::axis_setup_t           o
);
  import sbi_pkg::*;

  logic signed [AW-1:0] a2, b2, c2;
  logic signed [BW-1:0] lo, hi, ab;
  logic signed [NW-1:0] nlo, nhi;
  logic signed [AW-1:0] dd;
  logic        [AW-1:0] ad;

  always_comb begin
    a2  = {a, 1'b0};
    b2  = {b, 1'b0};
    c2  = {c, 1'b0};
    lo  = BW'(c2) - $signed({3'b000, s});
    hi  = BW'(c2) + $signed({3'b000, s});
    ab  = BW'(a2);
    nlo = NW'(lo) - NW'(a2);
    nhi = NW'(hi) - NW'(a2);
    dd  = $signed({b[CW-1], b}) - $signed({a[CW-1], a});
    ad  = dd[AW-1] ? AW'(-dd) : AW'(dd);

    o.in_a   = (ab > lo) && (ab < hi);
    o.in_b   = (BW'(b2) > lo) && (BW'(b2) < hi);
    o.par    = (ad == '0) || (ad < AW'(thr));
    o.pout   = (ab < lo) || (ab > hi);
    o.lo_neg = nlo[NW-1];
    o.hi_neg = nhi[NW-1];
    o.d_neg  = dd[AW-1];
    o.lo_mag = nlo[NW-1] ? NW'(-nlo) : NW'(nlo);
    o.hi_mag = nhi[NW-1] ? NW'(-nhi) : NW'(nhi);
    o.d_mag  = {ad, 1'b0};
    // quotient reaches 4.0 or more: saturates for sure
    o.lo_ovf = {1'b0, o.lo_mag} >= {o.d_mag, 2'b00};
    o.hi_ovf = {1'b0, o.hi_mag} >= {o.d_mag, 2'b00};
  end

endmodule

>>> rtl/sbi_div.sv
// Pipelined restoring divider, one quotient bit per stage, magnitudes only.
module sbi_div (
  input  logic                   clk,
  input  logic                   en,
  input  logic [sbi_pkg::NW-1:0] num_mag,
  input  logic [sbi_pkg::DW-1:0] den_mag,
  output logic [sbi_pkg::QB-1:0] q
);
  import sbi_pkg::*;

  logic [RW-1:0] rem [QB];
  logic [DW-1:0] den [QB];
  logic [QB-1:0] qq  [QB];

  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic [RW-1:0] pr, sub;
    logic [DW-1:0] pd;
    logic [QB-1:0] pq;
    logic          ge;

    if (k == 0) begin : g_first
      assign pr = {num_mag, {TF{1'b0}}};
      assign pd = den_mag;
      assign pq = '0;
    end else begin : g_next
      assign pr = rem[k-1];
      assign pd = den[k-1];
      assign pq = qq[k-1];
    end

    assign sub = RW'(pd) << (QB - 1 - k);
    assign ge  = pr >= sub;

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= ge ? pr - sub : pr;
        den[k] <= pd;
        qq[k]  <= pq | (ge ? (QB'(1) << (QB - 1 - k)) : '0);
      end
    end
  end

  assign q = qq[QB-1];

endmodule

>>> rtl/sbi_merge.sv
// Combines the three axis results: saturate, order, narrow the interval.
module sbi_merge (
  input  sbi_pkg::side_t                sb,
  input  logic [2:0][sbi_pkg::QB-1:0]   q_lo,
  input  logic [2:0][sbi_pkg::QB-1:0]   q_hi,
  output logic                          hit
);
  import sbi_pkg::*;

  localparam logic [QB-1:0] TLIM = QB'(1) << (TF + 1);
  localparam logic signed [TW-1:0] TONE = TW'(1) << TF;

  function automatic logic signed [TW-1:0] to_t(input logic [QB-1:0] m,
                                                 input logic ovf,
                                                 input logic neg);
    logic [QB-1:0] s;
    s = (ovf || (m > TLIM)) ? TLIM : m;
    return neg ? -$signed({1'b0, s}) : $signed({1'b0, s});
  endfunction

  logic signed [TW-1:0] t1, t2, u1, u2, tmin, tmax;
  logic                 pmiss;

  always_comb begin
    tmin  = '0;
    tmax  = TONE;
    pmiss = 1'b0;
    for (int i = 0; i < 3; i++) begin
      t1 = to_t(q_lo[i], sb.ovf_lo[i], sb.neg_lo[i]);
      t2 = to_t(q_hi[i], sb.ovf_hi[i], sb.neg_hi[i]);
      u1 = (t1 > t2) ? t2 : t1;
      u2 = (t1 > t2) ? t1 : t2;
      if (sb.par[i]) begin
        if (sb.pout[i]) pmiss = 1'b1;
      end else begin
        if (u1 > tmin) tmin = u1;
        if (u2 < tmax) tmax = u2;
      end
    end
    // interval only shrinks, so emptiness at the end equals emptiness anywhere
    hit = sb.enclosed || (!pmiss && !(tmin > tmax));
  end

endmodule

>>> rtl/segment_box_intersect.sv
// Segment/axis-aligned box slab hit test, one beat per cycle unless stalled.
//
//  channel | dir | beat                              | handshake
//  --------+-----+-----------------------------------+----------------------
//  s_*     | in  | segment A, B, box center and size | s_tvalid / s_tready
//  m_*     | out | hit flag                          | m_tvalid / m_tready
//  cfg_*   | in  | parallel_threshold                | cfg_valid / cfg_ready
//
// Throughput is one beat per cycle until the skid fills; each beat passes the
// setup register, the 18-stage quotient pipeline and the output register.
// Six dividers (two bounds on each of three axes) run side by side.
// Reset (rst, synchronous) clears the valid bits and sets the threshold to 1.
// A stalled output beat is caught by a one-entry skid; the pipeline halts
// only once the skid is full, so input is taken while a result waits.
module segment_box_intersect (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, center_x, center_y, center_z (24b each),
  // size_x, size_y, size_z (23b each), zero pad to 288
  input  logic [sbi_pkg::DBW-1:0]     s_tdata,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // hit, zero pad to 8
  output logic [sbi_pkg::OBW-1:0]     m_tdata,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [sbi_pkg::THW-1:0]     cfg_data
);
  import sbi_pkg::*;

  localparam int BOFF = 3 * CW;
  localparam int COFF = 6 * CW;
  localparam int SOFF = 9 * CW;

  logic [THW-1:0] thr;
  axis_setup_t    su [3];
  axis_setup_t    st [3];
  logic [QB:0]    v;            // setup stage plus divider stages
  side_t          sb  [QB];
  side_t          sb0;
  logic [2:0][QB-1:0] q_lo, q_hi;
  logic           hit_c;
  logic           en;
  logic           ov, sv, od, sd;

  // --- config register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THW'(1);
    end else if (cfg_valid) begin
      thr <= cfg_data;
    end
  end

  // --- per-axis setup lanes
  for (genvar i = 0; i < 3; i++) begin : g_axis
    sbi_axis u_axis (
      .a   (s_tdata[i*CW +: CW]),
      .b   (s_tdata[BOFF + i*CW +: CW]),
      .c   (s_tdata[COFF + i*CW +: CW]),
      .s   (s_tdata[SOFF + i*SW +: SW]),
      .thr (thr),
      .o   (su[i])
    );

    always_ff @(posedge clk) begin
      if (en) st[i] <= su[i];
    end

    sbi_div u_div_lo (
      .clk     (clk),
      .en      (en),
      .num_mag (st[i].lo_mag),
      .den_mag (st[i].d_mag),
      .q       (q_lo[i])
    );

    sbi_div u_div_hi (
      .clk     (clk),
      .en      (en),
      .num_mag (st[i].hi_mag),
      .den_mag (st[i].d_mag),
      .q       (q_hi[i])
    );

    assign sb0.par[i]    = st[i].par;
    assign sb0.pout[i]   = st[i].pout;
    assign sb0.neg_lo[i] = st[i].lo_neg ^ st[i].d_neg;
    assign sb0.neg_hi[i] = st[i].hi_neg ^ st[i].d_neg;
    assign sb0.ovf_lo[i] = st[i].lo_ovf;
    assign sb0.ovf_hi[i] = st[i].hi_ovf;
  end

  // either endpoint strictly inside: hit regardless of slabs
  assign sb0.enclosed = (st[0].in_a && st[1].in_a && st[2].in_a) ||
                        (st[0].in_b && st[1].in_b && st[2].in_b);

  // --- sideband runs beside the divider stages
  always_ff @(posedge clk) begin
    if (en) begin
      sb[0] <= sb0;
      for (int k = 1; k < QB; k++) sb[k] <= sb[k-1];
    end
  end

  // --- valid bits
  assign en       = !sv;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[QB-1:0], s_tvalid};
    end
  end

  sbi_merge u_merge (
    .sb   (sb[QB-1]),
    .q_lo (q_lo),
    .q_hi (q_hi),
    .hit  (hit_c)
  );

  // --- output register with one-entry skid
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      sv <= 1'b0;
    end else if (ov && !m_tready) begin
      if (en && v[QB]) sv <= 1'b1;
    end else if (sv) begin
      ov <= 1'b1;
      sv <= 1'b0;
    end else begin
      ov <= v[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (ov && !m_tready) begin
      if (en && v[QB]) sd <= hit_c;
    end else if (sv) begin
      od <= sd;
    end else begin
      od <= hit_c;
    end
  end

  assign m_tvalid = ov;
  assign m_tdata  = {{(OBW-1){1'b0}}, od};

endmodule

>>> tb/tb_top.sv
// Testbench for segment_box_intersect: predicts the hit flag per beat and checks every result.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import sbi_pkg::*;

  localparam int LATENCY   = QB + 2;
  localparam int WATCHDOG  = 20000;
  localparam int FILL_HOLD = 200;

  // modes of the idle generators
  typedef enum int {IDLE_NONE, IDLE_SRC, IDLE_SNK, IDLE_BOTH} idle_mode_t;

  typedef struct {
    logic signed [CW-1:0] a [3];
    logic signed [CW-1:0] b [3];
    logic signed [CW-1:0] c [3];
    logic [SW-1:0]        s [3];
  } seg_box_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [DBW-1:0] s_tdata = '0;  // a_x..b_z, center_x..z (24b), size_x..z (23b), pad
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OBW-1:0] m_tdata;       // hit, pad
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [THW-1:0] cfg_data = '0;

  always #1 clk = ~clk;

  segment_box_intersect uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // predictor state
  logic [THW-1:0] threshold = 8'd1;
  logic           hit_queue [$];
  int             errors = 0;
  int             beats_in = 0;
  int             beats_out = 0;
  int             hits_seen = 0;
  idle_mode_t     idle_mode = IDLE_NONE;
  bit             hold_sink = 1'b0;
  int             quiet = 0;

  function automatic longint sat_param(longint q);
    longint lim;
    lim = longint'(2) <<< TF;
    if (q > lim) return lim;
    if (q < -lim) return -lim;
    return q;
  endfunction

  // slab-method hit test in doubled units
  function automatic logic predict_hit(seg_box_t it, logic [THW-1:0] thr);
    longint pa [3];
    longint pb [3];
    longint lo [3];
    longint hi [3];
    longint one, tmin, tmax, d2, ad, t1, t2, tt;
    bit in_a, in_b;
    one = longint'(1) <<< TF;
    tmin = 0;
    tmax = one;
    in_a = 1;
    in_b = 1;
    for (int i = 0; i < 3; i++) begin
      pa[i] = 2 * longint'(it.a[i]);
      pb[i] = 2 * longint'(it.b[i]);
      lo[i] = 2 * longint'(it.c[i]) - longint'(it.s[i]);
      hi[i] = 2 * longint'(it.c[i]) + longint'(it.s[i]);
      if (!(pa[i] > lo[i] && pa[i] < hi[i])) in_a = 0;
      if (!(pb[i] > lo[i] && pb[i] < hi[i])) in_b = 0;
    end
    if (in_a || in_b) return 1'b1;
    for (int i = 0; i < 3; i++) begin
      d2 = pb[i] - pa[i];
      ad = (d2 < 0) ? -d2 / 2 : d2 / 2;
      if (d2 == 0 || ad < longint'(thr)) begin
        if (pa[i] < lo[i] || pa[i] > hi[i]) return 1'b0;
      end else begin
        t1 = sat_param(((lo[i] - pa[i]) * one) / d2);
        t2 = sat_param(((hi[i] - pa[i]) * one) / d2);
        if (t1 > t2) begin
          tt = t1;
          t1 = t2;
          t2 = tt;
        end
        if (t1 > tmin) tmin = t1;
        if (t2 < tmax) tmax = t2;
        if (tmin > tmax) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(string what);
    $display("MISMATCH @%0t: %s", $realtime, what);
    errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      beats_out++;
      if (hit_queue.size() == 0) begin
        report_mismatch("hit beat with nothing expected");
      end else begin
        logic want;
        want = hit_queue.pop_front();
        if (m_tdata[0] !== want)
          report_mismatch($sformatf("hit got %b want %b", m_tdata[0], want));
        if (want) hits_seen++;
      end
    end
  end

  // receiver stall generator
  always @(posedge clk) begin
    if (hold_sink)
      m_tready <= 1'b0;
    else if (idle_mode == IDLE_SNK)
      m_tready <= ($urandom_range(99) >= 69);
    else if (idle_mode == IDLE_BOTH)
      m_tready <= ($urandom_range(99) >= 8);
    else
      m_tready <= 1'b1;
  end

  // watchdog on cycles with no accepted beat
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || hold_sink || rst)
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet > WATCHDOG) begin
      $display("watchdog expired, %0d results outstanding", hit_queue.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_item(seg_box_t it);
    logic [DBW-1:0] w;
    int idle_pct;
    w = '0;
    for (int i = 0; i < 3; i++) begin
      w[i*CW +: CW]       = it.a[i];
      w[(3+i)*CW +: CW]   = it.b[i];
      w[(6+i)*CW +: CW]   = it.c[i];
      w[9*CW + i*SW +: SW] = it.s[i];
    end
    idle_pct = (idle_mode == IDLE_SRC) ? 69 : (idle_mode == IDLE_BOTH) ? 8 : 0;
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= w;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    hit_queue.push_back(predict_hit(it, threshold));
    beats_in++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (hit_queue.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_threshold(logic [THW-1:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    threshold = v;
  endtask

  function automatic logic signed [CW-1:0] rand_coord();
    case ($urandom_range(5))
      0: return {1'b1, {(CW-1){1'b0}}};
      1: return {1'b0, {(CW-1){1'b1}}};
      2: return CW'($urandom);
      default: return CW'($signed($urandom_range(4000)) - 2000);
    endcase
  endfunction

  function automatic logic [SW-1:0] rand_size();
    case ($urandom_range(4))
      0: return '0;
      1: return '1;
      2: return SW'($urandom);
      default: return SW'($urandom_range(3000));
    endcase
  endfunction

  // segments near a box so that slab tests, parallel axes and touches all occur
  function automatic seg_box_t rand_item();
    seg_box_t it;
    bit wild;
    wild = ($urandom_range(9) == 0);
    for (int i = 0; i < 3; i++) begin
      if (wild) begin
        it.c[i] = rand_coord();
        it.s[i] = rand_size();
        it.a[i] = rand_coord();
        it.b[i] = rand_coord();
      end else begin
        it.c[i] = CW'($signed($urandom_range(2000)) - 1000);
        it.s[i] = SW'($urandom_range(1200));
        it.a[i] = it.c[i] + CW'($signed($urandom_range(3000)) - 1500);
        case ($urandom_range(3))
          0: it.b[i] = it.a[i] + CW'($signed($urandom_range(8)) - 4);
          default: it.b[i] = it.c[i] + CW'($signed($urandom_range(3000)) - 1500);
        endcase
      end
    end
    return it;
  endfunction

  function automatic seg_box_t make_item(int ax, int ay, int az, int bx, int by, int bz,
                                         int cx, int cy, int cz, int sx, int sy, int sz);
    seg_box_t it;
    it.a = '{CW'(ax), CW'(ay), CW'(az)};
    it.b = '{CW'(bx), CW'(by), CW'(bz)};
    it.c = '{CW'(cx), CW'(cy), CW'(cz)};
    it.s = '{SW'(sx), SW'(sy), SW'(sz)};
    return it;
  endfunction

  task automatic test_directed();
    int mx, mn, sm;
    mx = 8388607;
    mn = -8388608;
    sm = 8388607;
    send_item(make_item(0, 0, 0, 5, 5, 5, 0, 0, 0, 100, 100, 100));       // A inside
    send_item(make_item(900, 0, 0, 0, 0, 0, 0, 0, 0, 100, 100, 100));     // B inside
    send_item(make_item(50, 0, 0, 900, 0, 0, 0, 0, 0, 100, 100, 100));    // A on face
    send_item(make_item(-500, 0, 0, 500, 0, 0, 0, 0, 0, 100, 100, 100));  // crosses
    send_item(make_item(-500, 200, 0, 500, 200, 0, 0, 0, 0, 100, 100, 100)); // parallel miss
    send_item(make_item(-500, 50, 0, 500, 50, 0, 0, 0, 0, 100, 100, 100));   // parallel on face
    send_item(make_item(-500, -500, 0, 500, 500, 0, 0, 0, 0, 0, 0, 0));   // flat box
    send_item(make_item(200, 200, 200, 300, 300, 300, 0, 0, 0, 100, 100, 100));
    send_item(make_item(mn, mn, mn, mx, mx, mx, 0, 0, 0, sm, sm, sm));
    send_item(make_item(mx, mx, mx, mn, mn, mn, mx, mn, mx, 0, sm, 1));
    send_item(make_item(mn, mx, mn, mn, mx, mn, mn, mx, mn, sm, sm, sm));
    send_item(make_item(-1, -1, -1, -1, -1, -1, mx, mx, mx, sm, sm, sm));
    send_item(make_item(10, 0, 0, 10, 900, 0, 0, 0, 0, 20, 100, 100));  // zero delta x
    send_item(make_item(-300, -300, 0, 300, 300, 0, 0, 0, 0, 100, 100, 100));
    send_item(make_item(-300, 300, 0, 300, -300, 0, 0, 200, 0, 100, 50, 100));
    drain();
  endtask

  task automatic test_random(idle_mode_t mode, int count);
    idle_mode = mode;
    for (int n = 0; n < count; n++) send_item(rand_item());
    drain();
    idle_mode = IDLE_NONE;
  endtask

  // receiver holds off while the sender keeps going, filling the pipeline
  task automatic test_backpressure();
    fork
      begin
        hold_sink = 1'b1;
        repeat (FILL_HOLD) @(posedge clk);
        hold_sink = 1'b0;
      end
      for (int n = 0; n < 60; n++) send_item(rand_item());
    join
    drain();
  endtask

  task automatic test_thresholds();
    logic [THW-1:0] vals [5];
    vals = '{8'd0, 8'd255, 8'd4, 8'd1, 8'd100};
    foreach (vals[k]) begin
      write_threshold(vals[k]);
      send_item(make_item(-500, 0, 0, 500, 3, 0, 0, 200, 0, 100, 100, 100));
      send_item(make_item(10, 0, 0, 10, 900, 0, 0, 0, 0, 20, 100, 100));
      test_random(IDLE_NONE, 40);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(IDLE_NONE, 300);
    test_random(IDLE_SRC, 250);
    test_random(IDLE_SNK, 250);
    test_random(IDLE_BOTH, 250);
    test_backpressure();
    test_thresholds();
    write_threshold(8'd1);
    test_random(IDLE_BOTH, 100);
    drain();
    $display("Covered %0d segment/box beats, %0d results (%0d hits),", beats_in, beats_out,
             hits_seen);
    $display("with thresholds 0..255, stalls on both sides and a filled pipeline.");
    if (errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
